FILE: design/ftrc_pkg.sv
// Shared types, codes and saturation helper for the force/torque record conditioner.
package ftrc_pkg;

  // Axis bookkeeping: three force axes followed by three torque axes.
  localparam int AXES = 6;
  localparam int AXIS_W = 3;
  localparam int FORCE_AXES = 3;
  localparam logic [AXIS_W-1:0] LAST_AXIS = 3'(AXES - 1);

  // Field widths.
  localparam int RAW_W = 32;
  localparam int VAL_W = 48;
  localparam int CNT_W = 32;
  localparam int SCALE_W = 32;
  localparam int ALPHA_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier operand and product widths.
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Request command codes.
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_TARE = 2'd1;
  localparam logic [1:0] CMD_UNTARE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_ALPHA = 2'd2;

  // Configuration reset values: unity scale and unity lowpass weight.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'h1_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic decide;
    logic mul_scale;
    logic clamp;
    logic mul_hi;
    logic mul_lo;
    logic update;
    logic load_out;
    logic [AXIS_W-1:0] axis;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic record_ok;
  } dp_status_t;

  // Saturate a signed 64-bit value to the signed 48-bit range.
  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] max_v;
    logic signed [63:0] min_v;
    max_v = 64'sh0000_7FFF_FFFF_FFFF;
    min_v = -64'sh0000_8000_0000_0000;
    if (v > max_v) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < min_v) begin
      return 48'sh8000_0000_0000;
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

FILE: design/ftrc_ctrl.sv
// Controller state machine that sequences one request through the axis loop.
module ftrc_ctrl
  import ftrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_SCALE  = 8'b0000_0100,
    S_CLAMP  = 8'b0000_1000,
    S_MUL_HI = 8'b0001_0000,
    S_MUL_LO = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic [AXIS_W-1:0] axis;
  logic [AXIS_W-1:0] axis_next;
  logic out_valid_next;
  logic slot_free;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Next state and axis counter.
  always_comb begin
    state_next = state;
    axis_next = axis;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        axis_next = '0;
        state_next = status.record_ok ? S_SCALE : S_DONE;
      end
      S_SCALE:  state_next = S_CLAMP;
      S_CLAMP:  state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_MUL_LO;
      S_MUL_LO: state_next = S_UPDATE;
      S_UPDATE: begin
        if (axis == LAST_AXIS) begin
          state_next = S_DONE;
        end else begin
          axis_next = axis + 1'b1;
          state_next = S_SCALE;
        end
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command decode for the datapath.
  always_comb begin
    cmd = '0;
    cmd.axis = axis;
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.decide = (state == S_DECIDE);
    cmd.mul_scale = (state == S_SCALE);
    cmd.clamp = (state == S_CLAMP);
    cmd.mul_hi = (state == S_MUL_HI);
    cmd.mul_lo = (state == S_MUL_LO);
    cmd.update = (state == S_UPDATE);
    cmd.load_out = (state == S_DONE) && slot_free;
  end

  // Output valid: set when a result loads, cleared when it is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis <= axis_next;
      out_valid <= out_valid_next;
    end
  end

  // A result never overwrites one that is still waiting.
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  // The axis counter stays within the six axes.
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis <= LAST_AXIS)
    else $error("axis counter out of range");

  // An accepted request always moves on to the decision step.
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DECIDE))
    else $error("accepted request not decided");

  // The last axis update ends the loop.
  a_last_axis_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && axis == LAST_AXIS) |=> (state == S_DONE))
    else $error("axis loop did not finish after the last axis");

endmodule

FILE: design/ftrc_dp.sv
// Datapath: request capture, counters, shared multiplier, lowpass and tare state.
module ftrc_dp
  import ftrc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  ctrl_cmd_t                    cmd,
  output dp_status_t                   status,
  input  logic [1:0]                   command,
  input  logic [31:0]                  hs_sequence,
  input  logic [31:0]                  sensor_status,
  input  logic signed [RAW_W-1:0]      raw_fx,
  input  logic signed [RAW_W-1:0]      raw_fy,
  input  logic signed [RAW_W-1:0]      raw_fz,
  input  logic signed [RAW_W-1:0]      raw_tx,
  input  logic signed [RAW_W-1:0]      raw_ty,
  input  logic signed [RAW_W-1:0]      raw_tz,
  output logic                         accepted,
  output logic signed [VAL_W-1:0]      out_fx,
  output logic signed [VAL_W-1:0]      out_fy,
  output logic signed [VAL_W-1:0]      out_fz,
  output logic signed [VAL_W-1:0]      out_tx,
  output logic signed [VAL_W-1:0]      out_ty,
  output logic signed [VAL_W-1:0]      out_tz,
  output logic [CNT_W-1:0]             good_count,
  output logic [CNT_W-1:0]             lost_count,
  output logic [CNT_W-1:0]             disorder_count,
  output logic [31:0]                  status_latch
);

  // Configuration registers.
  logic [SCALE_W-1:0] force_scale;
  logic [SCALE_W-1:0] torque_scale;
  logic [ALPHA_W-1:0] lowpass_alpha;

  // Captured request.
  logic [1:0] cmd_r;
  logic [31:0] seq_r;
  logic [31:0] status_r;
  logic signed [RAW_W-1:0] raw_r [AXES];

  // Architectural state.
  logic [31:0] prev_sequence;
  logic signed [VAL_W-1:0] lowpass_value [AXES];
  logic signed [VAL_W-1:0] tare_offset [AXES];
  logic signed [VAL_W-1:0] held_output [AXES];
  logic [CNT_W-1:0] good_total;
  logic [CNT_W-1:0] lost_total;
  logic [CNT_W-1:0] disorder_total;
  logic [31:0] status_hold;
  logic accepted_r;

  // Per-axis working registers.
  logic signed [PROD_W-1:0] prod_r;
  logic [MUL_W-1:0] lo_r;
  logic signed [VAL_W-1:0] x_r;

  // Combinational signals.
  logic [31:0] diff;
  logic record_ok;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [SCALE_W-1:0] scale_sel;
  logic signed [VAL_W-1:0] lp_sel;
  logic signed [VAL_W-1:0] tare_sel;
  logic signed [VAL_W:0] delta;
  logic signed [PROD_W-9:0] scaled_shift;
  logic signed [63:0] lp_sum;
  logic signed [63:0] out_diff;

  // Sequence check: a positive wrapped difference means in order.
  assign diff = seq_r - prev_sequence;
  assign record_ok = (cmd_r == CMD_RECORD) && (diff != '0) && !diff[31];
  assign status.record_ok = record_ok;

  // Operand selection for the current axis.
  assign scale_sel = (cmd.axis < AXIS_W'(FORCE_AXES)) ? force_scale : torque_scale;
  assign lp_sel = lowpass_value[cmd.axis];
  assign tare_sel = tare_offset[cmd.axis];
  assign delta = {x_r[VAL_W-1], x_r} - {lp_sel[VAL_W-1], lp_sel};

  // Shared multiplier: raw times scale, then alpha times the high and low
  // parts of the lowpass error.
  always_comb begin
    mul_a = {raw_r[cmd.axis][RAW_W-1], raw_r[cmd.axis]};
    mul_b = {1'b0, scale_sel};
    if (cmd.mul_hi) begin
      mul_a = delta[VAL_W:16];
      mul_b = {{(MUL_W-ALPHA_W){1'b0}}, lowpass_alpha};
    end else if (cmd.mul_lo) begin
      mul_a = {{(MUL_W-16){1'b0}}, delta[15:0]};
      mul_b = {{(MUL_W-ALPHA_W){1'b0}}, lowpass_alpha};
    end
  end
  assign mul_p = mul_a * mul_b;

  // Floor shift of the Q.24 product down to Q.16.
  assign scaled_shift = prod_r[PROD_W-1:8];

  // Lowpass update: lp + alpha*dh + floor(alpha*dl / 2^16).
  assign lp_sum = {{(64-VAL_W){lp_sel[VAL_W-1]}}, lp_sel}
                + $signed(prod_r[63:0])
                + $signed({{(64-17){1'b0}}, lo_r[MUL_W-1:16]});
  assign out_diff = {{(64-VAL_W){x_r[VAL_W-1]}}, x_r}
                  - {{(64-VAL_W){tare_sel[VAL_W-1]}}, tare_sel};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      force_scale <= SCALE_RESET;
      torque_scale <= SCALE_RESET;
      lowpass_alpha <= ALPHA_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_FORCE_SCALE:   force_scale <= cfg_data;
        REG_TORQUE_SCALE:  torque_scale <= cfg_data;
        REG_LOWPASS_ALPHA: lowpass_alpha <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= command;
      seq_r <= hs_sequence;
      status_r <= sensor_status;
      raw_r[0] <= raw_fx;
      raw_r[1] <= raw_fy;
      raw_r[2] <= raw_fz;
      raw_r[3] <= raw_tx;
      raw_r[4] <= raw_ty;
      raw_r[5] <= raw_tz;
    end
  end

  // Per-axis working registers.
  always_ff @(posedge clk) begin
    if (cmd.mul_scale || cmd.mul_hi) prod_r <= mul_p;
    if (cmd.mul_lo) lo_r <= mul_p[MUL_W-1:0];
    if (cmd.clamp) x_r <= sat48({{(64-(PROD_W-8)){scaled_shift[PROD_W-9]}}, scaled_shift});
  end

  // Sequence bookkeeping, counters, tare commands and axis updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sequence <= '0;
      good_total <= '0;
      lost_total <= '0;
      disorder_total <= '0;
      status_hold <= '0;
      accepted_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        lowpass_value[i] <= '0;
        tare_offset[i] <= '0;
        held_output[i] <= '0;
      end
    end else begin
      if (cmd.decide) begin
        accepted_r <= record_ok;
        case (cmd_r)
          CMD_RECORD: begin
            prev_sequence <= seq_r;
            if (status_r != '0) status_hold <= status_r;
            if (record_ok) begin
              good_total <= good_total + 1'b1;
              lost_total <= lost_total + diff - 1'b1;
            end else begin
              disorder_total <= disorder_total + 1'b1;
            end
          end
          CMD_TARE: begin
            for (int i = 0; i < AXES; i++) tare_offset[i] <= lowpass_value[i];
          end
          CMD_UNTARE: begin
            for (int i = 0; i < AXES; i++) tare_offset[i] <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.update) begin
        lowpass_value[cmd.axis] <= sat48(lp_sum);
        held_output[cmd.axis] <= sat48(out_diff);
      end
    end
  end

  // Output register snapshot of the result.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      accepted <= accepted_r;
      out_fx <= held_output[0];
      out_fy <= held_output[1];
      out_fz <= held_output[2];
      out_tx <= held_output[3];
      out_ty <= held_output[4];
      out_tz <= held_output[5];
      good_count <= good_total;
      lost_count <= lost_total;
      disorder_count <= disorder_total;
      status_latch <= status_hold;
    end
  end

endmodule

FILE: design/force_torque_record_conditioner_top.sv
// A sensor record in order passes the decision step and the axis loop before its
// result loads; a dropped record, tare, untare or unused command skips the loop.
// Requests are taken one at a time: an in-order record runs the five-step axis loop
// (scale, clamp, two lowpass products, update) on one shared 33x33 multiplier.
// A finished result waits until the previous one is taken, stalling new requests.
// Reset (synchronous, active high) clears counters, lowpass, tare and held outputs.
module force_torque_record_conditioner_top
  import ftrc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              command,
  input  logic [31:0]             hs_sequence,
  input  logic [31:0]             sensor_status,
  input  logic signed [RAW_W-1:0] raw_fx,
  input  logic signed [RAW_W-1:0] raw_fy,
  input  logic signed [RAW_W-1:0] raw_fz,
  input  logic signed [RAW_W-1:0] raw_tx,
  input  logic signed [RAW_W-1:0] raw_ty,
  input  logic signed [RAW_W-1:0] raw_tz,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    accepted,
  output logic signed [VAL_W-1:0] out_fx,
  output logic signed [VAL_W-1:0] out_fy,
  output logic signed [VAL_W-1:0] out_fz,
  output logic signed [VAL_W-1:0] out_tx,
  output logic signed [VAL_W-1:0] out_ty,
  output logic signed [VAL_W-1:0] out_tz,
  output logic [CNT_W-1:0]        good_count,
  output logic [CNT_W-1:0]        lost_count,
  output logic [CNT_W-1:0]        disorder_count,
  output logic [31:0]             status_latch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer for the request and the axis loop.
  ftrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic, state and output register.
  ftrc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .command        (command),
    .hs_sequence    (hs_sequence),
    .sensor_status  (sensor_status),
    .raw_fx         (raw_fx),
    .raw_fy         (raw_fy),
    .raw_fz         (raw_fz),
    .raw_tx         (raw_tx),
    .raw_ty         (raw_ty),
    .raw_tz         (raw_tz),
    .accepted       (accepted),
    .out_fx         (out_fx),
    .out_fy         (out_fy),
    .out_fz         (out_fz),
    .out_tx         (out_tx),
    .out_ty         (out_ty),
    .out_tz         (out_tz),
    .good_count     (good_count),
    .lost_count     (lost_count),
    .disorder_count (disorder_count),
    .status_latch   (status_latch)
  );

endmodule

FILE: dv/ftrc_check_pkg.sv
// Scoreboard class and result type for checking the force/torque record conditioner.
`timescale 1ns / 100ps
package ftrc_check_pkg;
  import ftrc_pkg::*;

  // Codes that the design package leaves unnamed.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd3;

  // Limits of the signed 48-bit Q.16 range.
  localparam longint VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VALUE_MIN = -VALUE_MAX - 1;

  typedef logic signed [RAW_W-1:0] count_array_t [AXES];

  // One conditioned result as the block presents it.
  typedef struct packed {
    logic                        accepted;
    logic [AXES-1:0][VAL_W-1:0]  axis;
    logic [CNT_W-1:0]            good;
    logic [CNT_W-1:0]            lost;
    logic [CNT_W-1:0]            disorder;
    logic [31:0]                 status;
  } ft_result_t;

  class ft_scoreboard;
    // Configuration copy.
    logic [SCALE_W-1:0] force_scale;
    logic [SCALE_W-1:0] torque_scale;
    logic [ALPHA_W-1:0] alpha;

    // Conditioner state copy.
    logic [31:0]      seq_seen;
    logic [CNT_W-1:0] good_n;
    logic [CNT_W-1:0] lost_n;
    logic [CNT_W-1:0] disorder_n;
    logic [31:0]      status_seen;
    longint           lp_state [AXES];
    longint           tare_ofs [AXES];
    longint           shown [AXES];

    ft_result_t results_due [$];
    int unsigned fault_count;

    function new();
      force_scale = SCALE_RESET;
      torque_scale = SCALE_RESET;
      alpha = ALPHA_RESET;
      seq_seen = '0;
      good_n = '0;
      lost_n = '0;
      disorder_n = '0;
      status_seen = '0;
      foreach (lp_state[i]) begin
        lp_state[i] = 0;
        tare_ofs[i] = 0;
        shown[i] = 0;
      end
      fault_count = 0;
    endfunction

    function longint clamp48(longint v);
      if (v > VALUE_MAX) return VALUE_MAX;
      if (v < VALUE_MIN) return VALUE_MIN;
      return v;
    endfunction

    // Q.24 product shifted down to Q.16 with floor rounding.
    function longint scale_count(logic signed [RAW_W-1:0] raw, logic [SCALE_W-1:0] scale);
      longint prod;
      prod = longint'(raw) * longint'({32'd0, scale});
      return clamp48(prod >>> 8);
    endfunction

    // First-order lowpass step, exact product, floor of the weighted difference.
    function longint lowpass_next(longint lp, longint x);
      logic signed [80:0] weighted;
      longint diff;
      diff = x - lp;
      weighted = $signed({1'b0, alpha}) * diff;
      return clamp48(lp + longint'(weighted >>> 16));
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FORCE_SCALE:   force_scale = data;
        REG_TORQUE_SCALE:  torque_scale = data;
        REG_LOWPASS_ALPHA: alpha = data[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(logic [1:0] cmd, logic [31:0] seq, logic [31:0] status,
                               count_array_t raw);
      ft_result_t r;
      logic [31:0] gap;
      longint x;
      r = '0;
      case (cmd)
        CMD_RECORD: begin
          gap = seq - seq_seen;
          if (status != 0) status_seen = status;
          seq_seen = seq;
          if (gap == 0 || gap[31]) begin
            disorder_n++;
          end else begin
            for (int i = 0; i < AXES; i++) begin
              x = scale_count(raw[i], (i < FORCE_AXES) ? force_scale : torque_scale);
              lp_state[i] = lowpass_next(lp_state[i], x);
              shown[i] = clamp48(x - tare_ofs[i]);
            end
            lost_n += gap - 32'd1;
            good_n++;
            r.accepted = 1'b1;
          end
        end
        CMD_TARE: tare_ofs = lp_state;
        CMD_UNTARE: begin
          foreach (tare_ofs[i]) tare_ofs[i] = 0;
        end
        default: ;
      endcase
      foreach (shown[i]) r.axis[i] = shown[i][VAL_W-1:0];
      r.good = good_n;
      r.lost = lost_n;
      r.disorder = disorder_n;
      r.status = status_seen;
      results_due.push_back(r);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // Compare one accepted result with the oldest outstanding one.
    function void check_result(ft_result_t got);
      ft_result_t want;
      if (results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result arrived with no request outstanding");
        return;
      end
      want = results_due.pop_front();
      if (got.accepted != want.accepted) report("accepted", want.accepted, got.accepted);
      for (int i = 0; i < AXES; i++) begin
        if (got.axis[i] != want.axis[i])
          report($sformatf("axis %0d", i), want.axis[i], got.axis[i]);
      end
      if (got.good != want.good) report("good_count", want.good, got.good);
      if (got.lost != want.lost) report("lost_count", want.lost, got.lost);
      if (got.disorder != want.disorder) report("disorder_count", want.disorder, got.disorder);
      if (got.status != want.status) report("status_latch", want.status, got.status);
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench for the force/torque record conditioner.
`timescale 1ns / 100ps
module tb_top
  import ftrc_pkg::*;
  import ftrc_check_pkg::*;
();

  logic                    clk;
  logic                    rst;
  logic                    cfg_wen;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              command;
  logic [31:0]             hs_sequence;
  logic [31:0]             sensor_status;
  logic signed [RAW_W-1:0] axis_raw [AXES];
  logic                    out_valid;
  logic                    out_stall;
  logic                    accepted;
  logic signed [VAL_W-1:0] axis_out [AXES];
  logic [CNT_W-1:0]        good_count;
  logic [CNT_W-1:0]        lost_count;
  logic [CNT_W-1:0]        disorder_count;
  logic [31:0]             status_latch;

  bit          idle_on;
  logic [31:0] gen_seq;

  ft_scoreboard sb = new();

  force_torque_record_conditioner_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .hs_sequence    (hs_sequence),
    .sensor_status  (sensor_status),
    .raw_fx         (axis_raw[0]),
    .raw_fy         (axis_raw[1]),
    .raw_fz         (axis_raw[2]),
    .raw_tx         (axis_raw[3]),
    .raw_ty         (axis_raw[4]),
    .raw_tz         (axis_raw[5]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accepted       (accepted),
    .out_fx         (axis_out[0]),
    .out_fy         (axis_out[1]),
    .out_fz         (axis_out[2]),
    .out_tx         (axis_out[3]),
    .out_ty         (axis_out[4]),
    .out_tz         (axis_out[5]),
    .good_count     (good_count),
    .lost_count     (lost_count),
    .disorder_count (disorder_count),
    .status_latch   (status_latch)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Watch both handshakes; values are taken as they stood before the edge.
  always @(posedge clk) begin : watch
    ft_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(command, hs_sequence, sensor_status, axis_raw);
      if (out_valid && !out_stall) begin
        got.accepted = accepted;
        foreach (axis_out[i]) got.axis[i] = axis_out[i];
        got.good = good_count;
        got.lost = lost_count;
        got.disorder = disorder_count;
        got.status = status_latch;
        sb.check_result(got);
      end
    end
  end

  // Result side stalls in random bursts while idling is enabled.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [RAW_W-1:0] rand_count();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return '1;
      4, 5: return $signed(32'($urandom_range(0, 4000))) - 32'sd2000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($urandom_range(0, 32'h0200_0000));
      2: return SCALE_RESET;
      3: return 32'hFFFF_FFFF;
      default: return '0;
    endcase
  endfunction

  // Present one request, with an optional gap first, and hold it until taken.
  task automatic push_request(input logic [1:0] cmd, input logic [31:0] seq,
                              input logic [31:0] status, input count_array_t raw);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    hs_sequence <= seq;
    sensor_status <= status;
    foreach (axis_raw[i]) axis_raw[i] <= raw[i];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_uniform(input logic [1:0] cmd, input logic [31:0] seq,
                              input logic [31:0] status, input logic signed [RAW_W-1:0] value);
    count_array_t raw;
    foreach (raw[i]) raw[i] = value;
    push_request(cmd, seq, status, raw);
  endtask

  // Mostly in-order records, with gaps, repeats, stale and wild sequences and commands.
  task automatic send_random_item();
    count_array_t raw;
    logic [31:0] seq;
    int pick;
    foreach (raw[i]) raw[i] = rand_count();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      push_request(CMD_TARE, $urandom, $urandom, raw);
    end else if (pick < 10) begin
      push_request(CMD_UNTARE, $urandom, $urandom, raw);
    end else if (pick < 12) begin
      push_request(CMD_RESERVED, $urandom, $urandom, raw);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 78) seq = gen_seq + 32'd1;
      else if (pick < 86) seq = gen_seq + 32'($urandom_range(2, 20));
      else if (pick < 90) seq = $urandom;
      else if (pick < 95) seq = gen_seq;
      else seq = gen_seq - 32'($urandom_range(1, 50));
      gen_seq = seq;
      push_request(CMD_RECORD, seq, ($urandom_range(0, 6) == 0) ? $urandom : 32'd0, raw);
    end
  endtask

  task automatic run_phase(input int n, input bit idle);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) idle_on = idle && ($urandom_range(0, 3) != 0);
      send_random_item();
    end
  endtask

  // Stop sending, let every outstanding result come out, then let the pipeline settle.
  // The first edge lets the last accepted request reach the scoreboard.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Write all registers, the unused index included, while the block is idle.
  task automatic write_regs(input logic [31:0] fs, input logic [31:0] ts,
                            input logic [ALPHA_W-1:0] al);
    write_one(REG_FORCE_SCALE, fs);
    write_one(REG_TORQUE_SCALE, ts);
    write_one(REG_LOWPASS_ALPHA, {15'($urandom), al});
    write_one(REG_RESERVED, $urandom);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    idle_on = 1'b0;
    gen_seq = '0;
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_index <= REG_FORCE_SCALE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    command <= CMD_RECORD;
    hs_sequence <= '0;
    sensor_status <= '0;
    foreach (axis_raw[i]) axis_raw[i] <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at reset configuration, where the lowpass tracks its input.
    idle_on = 1'b1;
    send_uniform(CMD_RECORD, 32'd1, 32'd0, 32'sh7FFF_FFFF);
    send_uniform(CMD_RECORD, 32'd2, 32'd0, 32'sh8000_0000);
    send_uniform(CMD_TARE, 32'd0, 32'd0, '0);
    // Full-scale positive over a full-scale negative offset saturates high.
    send_uniform(CMD_RECORD, 32'd3, 32'd0, 32'sh7FFF_FFFF);
    send_uniform(CMD_UNTARE, 32'd0, 32'd0, '0);
    send_uniform(CMD_RECORD, 32'd4, 32'hFFFF_FFFF, '0);
    // Repeated and then stale sequence numbers are dropped.
    send_uniform(CMD_RECORD, 32'd4, 32'd0, 32'sd5);
    send_uniform(CMD_RECORD, 32'd2, 32'd1, 32'sd7);
    send_uniform(CMD_RECORD, 32'd12, 32'd0, -32'sd1234567);
    // A jump of exactly half the sequence range counts as out of order.
    send_uniform(CMD_RECORD, 32'h8000_000C, 32'd0, 32'sd99);
    send_uniform(CMD_RECORD, 32'h8000_000D, 32'd0, 32'sd1);
    send_uniform(CMD_RESERVED, $urandom, $urandom, 32'sh5A5A_5A5A);
    send_uniform(CMD_RECORD, 32'hFFFF_FFFF, 32'd0, '1);
    // Sequence wrap from all ones to zero is in order.
    send_uniform(CMD_RECORD, 32'd0, 32'd0, 32'sh7FFF_FFFF);
    send_uniform(CMD_TARE, 32'd0, 32'd0, '0);
    send_uniform(CMD_RECORD, 32'd1, 32'd0, 32'sh8000_0000);
    send_uniform(CMD_UNTARE, 32'd0, 32'd0, '0);
    gen_seq = 32'd1;

    // Random phases over a spread of configurations, extremes first.
    run_phase(190, 1'b1);
    drain();
    write_regs(32'hFFFF_FFFF, 32'h0000_0000, 17'h1_FFFF);
    run_phase(210, 1'b1);
    drain();
    write_regs(32'h0000_0000, 32'hFFFF_FFFF, 17'h0_0000);
    run_phase(210, 1'b1);
    drain();
    write_regs(32'h0000_0001, 32'h0100_0001, 17'h0_0001);
    run_phase(210, 1'b1);
    drain();
    write_regs(rand_scale(), rand_scale(), 17'($urandom));
    run_phase(210, 1'b1);
    drain();
    write_regs(32'h00F0_0000 + 32'($urandom_range(0, 32'h0020_0000)), rand_scale(),
               17'($urandom_range(1, 65536)));
    run_phase(200, 1'b0);

    // Wind down and report.
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
